FILE: design/bsb_pkg.sv
package bsb_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned MAX_CTRL_POINTS = 64;
  localparam int unsigned MAX_DEGREE      = 7;
  localparam logic [32:0] UNIT_Q = 33'h0_8000_0000;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PROBE  = 9'b000000010,
    ST_CMP    = 9'b000000100,
    ST_LDK    = 9'b000001000,
    ST_LDW    = 9'b000010000,
    ST_TERM   = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_ACC    = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic        big;
  } div_rsp_t;

endpackage

FILE: design/bspline_span_and_basis_unit.sv
// B-spline span search and basis evaluation unit.
// Command channel: raise start with in_operation and its fields while busy
// is low; the word is taken at that edge and busy rises for its work.
// in_operation 0 writes in_knot_value to knot slot in_knot_index (slots
// past the store are ignored); the write lands at the accepting edge, busy
// stays low and no result follows.
// in_operation 1 evaluates at in_param_u: a first read of knot[n], then up
// to seven binary-search probes on the one RAM read port find the span;
// each left/right pair is then loaded from the knot store, and
// degree*(degree+1) product-quotient terms run through one shared 64/32
// restoring divider (one quotient bit per cycle; a term that is zero skips
// the divider).
// Results leave one per cycle on out_valid, basis_index 0 first, with
// out_last on the final one; the receiver must take each as it comes.
// Config writes on cfg_we are taken any cycle the unit is idle.
// Reset (synchronous, rst_n low) sets n=4, p=3 and idles the unit; the
// knot store is not cleared and must be written before it is read.
module bspline_span_and_basis_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [6:0]  in_knot_index,
  input  logic [31:0] in_knot_value,
  input  logic [31:0] in_param_u,
  output logic        out_valid,
  output logic [5:0]  out_span_index,
  output logic [2:0]  out_basis_index,
  output logic [31:0] out_basis_value,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import bsb_pkg::*;

  localparam int unsigned DEPTH = MAX_CTRL_POINTS + MAX_DEGREE + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned JW    = $clog2(MAX_DEGREE + 1);

  logic [6:0] ncfg_r;
  logic [2:0] pcfg_r;

  state_t st_r, st_nxt;
  logic [AW:0]  n_r, n_nxt, lo_r, lo_nxt, hi_r, hi_nxt, s_r, s_nxt;
  logic [31:0]  u_r, u_nxt, ks_r, ks_nxt;
  logic [JW-1:0] p_r, p_nxt, j_r, j_nxt, r_r, r_nxt, k_r, k_nxt;
  logic [1:0]   ph_r, ph_nxt;
  logic         tsel_r, tsel_nxt;
  logic [32:0]  nb_r [MAX_DEGREE+1];
  logic [32:0]  nb_nxt [MAX_DEGREE+1];
  logic signed [33:0] lft_r [MAX_DEGREE+1];
  logic signed [33:0] lft_nxt [MAX_DEGREE+1];
  logic signed [33:0] rgt_r [MAX_DEGREE+1];
  logic signed [33:0] rgt_nxt [MAX_DEGREE+1];
  logic [32:0]  saved_r, saved_nxt, ta_r, ta_nxt;
  logic [63:0]  prod_r, prod_nxt;
  logic [31:0]  den_r, den_nxt;
  logic         zero_r, zero_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;

  logic [6:0]  nc;
  logic [2:0]  pc;
  logic [AW:0] mid;
  logic signed [34:0] dsum;
  logic signed [33:0] num;
  logic [32:0] q, sum;

  bsb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(in_knot_value),
    .raddr(raddr), .rdata(rdata)
  );

  bsb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign we    = start && !busy && !in_operation && ({1'b0, in_knot_index} < 8'(DEPTH));
  assign waddr = AW'(in_knot_index);
  assign busy  = (st_r != ST_IDLE);
  assign mid   = (AW+1)'((lo_r + hi_r) >> 1);

  always_comb begin
    nc = ncfg_r;
    pc = pcfg_r;
    if (nc < 7'd2) nc = 7'd2;
    if (32'(nc) > MAX_CTRL_POINTS) nc = 7'(MAX_CTRL_POINTS);
    if (pc < 3'd1) pc = 3'd1;
    if (32'(pc) > MAX_DEGREE) pc = 3'(MAX_DEGREE);
    if ({4'd0, pc} >= nc) nc = {4'd0, pc} + 7'd1;
  end

  always_comb begin
    raddr = AW'(s_r);
    unique case (st_r)
      ST_LDK:  raddr = ph_r[0] ? AW'(s_r + (AW+1)'(j_r))
                               : AW'(s_r + 1'b1 - (AW+1)'(j_r));
      ST_CMP:  raddr = AW'(s_r + 1'b1);
      default: raddr = AW'(s_r);
    endcase
  end

  always_comb begin
    dsum = 35'(rgt_r[r_r + 1'b1]) + 35'(lft_r[j_r - r_r]);
    num  = tsel_r ? lft_r[j_r - r_r] : rgt_r[r_r + 1'b1];
    q    = drsp.big ? UNIT_Q : {1'b0, drsp.quot};
    if (q > UNIT_Q) q = UNIT_Q;
    sum  = saved_r + ta_r;
    if (sum > UNIT_Q) sum = UNIT_Q;
  end

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; lo_nxt = lo_r; hi_nxt = hi_r; s_nxt = s_r;
    u_nxt = u_r; ks_nxt = ks_r; p_nxt = p_r; j_nxt = j_r; r_nxt = r_r;
    k_nxt = k_r; ph_nxt = ph_r; tsel_nxt = tsel_r; saved_nxt = saved_r;
    ta_nxt = ta_r; prod_nxt = prod_r; den_nxt = den_r; zero_nxt = zero_r;
    nb_nxt = nb_r; lft_nxt = lft_r; rgt_nxt = rgt_r;
    dreq = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (start && in_operation) begin
          n_nxt  = (AW+1)'(nc);
          p_nxt  = JW'(pc);
          lo_nxt = (AW+1)'(pc);
          hi_nxt = (AW+1)'(nc);
          s_nxt  = (AW+1)'(nc);
          u_nxt  = in_param_u;
          ph_nxt = 2'd0;
          nb_nxt[0] = UNIT_Q;
          st_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // first read is knot[n]; then knot[mid]
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          if (u_r >= rdata) begin
            s_nxt = n_r - 1'b1;
            st_nxt = ST_LDK;
            j_nxt = JW'(1);
            ph_nxt = 2'd0;
          end else begin
            s_nxt = mid;
            ph_nxt = 2'd2;
          end
        end else begin
          st_nxt = ST_CMP;
          ph_nxt = 2'd0;
        end
      end
      ST_CMP: begin
        if (ph_r == 2'd0) begin
          ks_nxt = rdata;
          ph_nxt = 2'd1;
        end else if ((hi_r - lo_r) <= 1 || (u_r >= ks_r && u_r < rdata)) begin
          st_nxt = ST_LDK;
          j_nxt = JW'(1);
          ph_nxt = 2'd0;
        end else begin
          if (u_r < ks_r) begin
            hi_nxt = s_r;
            s_nxt = (AW+1)'((lo_r + s_r) >> 1);
          end else begin
            lo_nxt = s_r;
            s_nxt = (AW+1)'((s_r + hi_r) >> 1);
          end
          st_nxt = ST_PROBE;
          ph_nxt = 2'd2;
        end
      end
      ST_LDK: begin
        if (ph_r == 2'd0) begin
          ph_nxt = 2'd2;
        end else if (ph_r == 2'd2) begin
          lft_nxt[j_r] = 34'(u_r) - 34'(rdata);
          ph_nxt = 2'd1;
        end else if (ph_r == 2'd1) begin
          ph_nxt = 2'd3;
        end else begin
          rgt_nxt[j_r] = 34'(rdata) - 34'(u_r);
          st_nxt = ST_LDW;
          r_nxt = '0;
          saved_nxt = '0;
          tsel_nxt = 1'b0;
        end
      end
      ST_LDW: begin
        zero_nxt = (num <= 0) || (dsum <= 0);
        prod_nxt = 64'(num[32:0]) * 64'(nb_r[r_r]);
        den_nxt = dsum[31:0];
        st_nxt = ST_TERM;
      end
      ST_TERM: begin
        if (zero_r) begin
          if (!tsel_r) ta_nxt = '0;
          st_nxt = ST_ACC;
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = prod_r;
          dreq.divisor = den_r;
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          if (!tsel_r) ta_nxt = q;
          else saved_nxt = q;
          st_nxt = ST_ACC;
          zero_nxt = 1'b0;
        end
      end
      ST_ACC: begin
        if (!tsel_r) begin
          ta_nxt = sum;
          tsel_nxt = 1'b1;
          st_nxt = ST_LDW;
        end else begin
          if (zero_r) saved_nxt = '0;
          nb_nxt[r_r] = ta_r;
          tsel_nxt = 1'b0;
          if (r_r + 1'b1 == j_r) begin
            nb_nxt[j_r] = zero_r ? 33'd0 : saved_r;
            if (j_r == p_r) begin
              st_nxt = ST_EMIT;
              k_nxt = '0;
            end else begin
              j_nxt = j_r + 1'b1;
              st_nxt = ST_LDK;
              ph_nxt = 2'd0;
            end
          end else begin
            r_nxt = r_r + 1'b1;
            st_nxt = ST_LDW;
            saved_nxt = zero_r ? 33'd0 : saved_r;
          end
        end
      end
      ST_EMIT: begin
        if (k_r == p_r) st_nxt = ST_IDLE;
        else k_nxt = k_r + 1'b1;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ncfg_r <= 7'd4;
      pcfg_r <= 3'd3;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && !busy) begin
        if (cfg_index) pcfg_r <= cfg_data[2:0];
        else ncfg_r <= cfg_data;
      end
    end
    n_r <= n_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; s_r <= s_nxt;
    u_r <= u_nxt; ks_r <= ks_nxt; p_r <= p_nxt; j_r <= j_nxt;
    r_r <= r_nxt; k_r <= k_nxt; ph_r <= ph_nxt; tsel_r <= tsel_nxt;
    ta_r <= ta_nxt; prod_r <= prod_nxt; den_r <= den_nxt;
    zero_r <= zero_nxt; nb_r <= nb_nxt; lft_r <= lft_nxt; rgt_r <= rgt_nxt;
    saved_r <= saved_nxt;
  end

  assign out_valid       = (st_r == ST_EMIT);
  assign out_span_index  = 6'(s_r);
  assign out_basis_index = 3'(k_r);
  assign out_basis_value = nb_r[k_r][31:0];
  assign out_last        = (k_r == p_r);

endmodule

FILE: design/bsb_ram.sv
module bsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bsb_div.sv
module bsb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bsb_pkg::div_req_t req,
  output bsb_pkg::div_rsp_t rsp
);
  import bsb_pkg::*;

  logic [63:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        big_r, big_nxt;
  logic [32:0] sh;
  logic [33:0] dif;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    big_nxt = big_r;
    sh      = {rem_r[31:0], num_r[63]};
    dif     = {1'b0, sh} - {2'b0, den_r};
    if (req.start) begin
      num_nxt = req.dividend;
      den_nxt = req.divisor;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      run_nxt = 1'b1;
      big_nxt = 1'b0;
    end else if (run_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      if (!dif[33]) begin
        rem_nxt = dif[32:0];
        num_nxt[0] = 1'b1;
        if (cnt_r > 7'd32) begin
          big_nxt = 1'b1;
        end
      end else begin
        rem_nxt = sh;
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    big_r <= big_nxt;
  end

  assign rsp.done = run_r && (cnt_r == 7'd1) && !req.start;
  assign rsp.quot = num_nxt[31:0];
  assign rsp.big  = big_nxt || (num_nxt[63:32] != 32'd0);

endmodule

FILE: tb/sv/bspline_span_and_basis_unit_tb.sv
`timescale 1ns / 100ps

module bspline_span_and_basis_unit_tb;
  import bsb_pkg::*;

  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_EVAL  = 1'b1;
  localparam bit REG_CTRL_PTS = 1'b0;
  localparam bit REG_DEGREE   = 1'b1;
  localparam int STORE_DEPTH = 72;
  localparam bit [31:0] ONE_Q = 32'h8000_0000;
  localparam int SETTLE_CYCLES = 8;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} cmd_kind_t;

  typedef struct {
    cmd_kind_t  kind;
    bit         op;
    bit [6:0]   idx;
    bit [31:0]  kval;
    bit [31:0]  u;
    bit         reg_sel;
    bit [6:0]   reg_val;
  } cmd_t;

  typedef struct {
    bit [5:0]  span;
    bit [2:0]  bidx;
    bit [31:0] val;
    bit        last;
  } basis_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = 1'b0;
  logic [6:0]  in_knot_index = '0;
  logic [31:0] in_knot_value = '0;
  logic [31:0] in_param_u = '0;
  logic        out_valid;
  logic [5:0]  out_span_index;
  logic [2:0]  out_basis_index;
  logic [31:0] out_basis_value;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;

  bspline_span_and_basis_unit dut (.*);

  cmd_t        pending[$];
  basis_word_t expected_basis[$];
  cmd_t        cur;

  bit [31:0] knots_m[STORE_DEPTH];
  bit [6:0]  ctrl_pts_m = 7'd4;
  bit [2:0]  degree_m = 3'd3;

  bit [31:0] knots_f[STORE_DEPTH];
  int  fill_n = 4, fill_p = 3;

  int  gap = 0, settle = 0;
  int  errors = 0, n_evals = 0, n_writes = 0, n_words = 0, n_phases = 0;
  longint cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic void eff_np(input int rn, input int rp, output int n, output int p);
    n = rn; p = rp;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    if (p < 1) p = 1;
    if (p > 7) p = 7;
    if (p >= n) n = p + 1;
  endfunction

  function automatic bit [32:0] scaled_term(input longint num, input bit [32:0] nv,
                                            input longint den);
    bit [127:0] prd;
    bit [127:0] q;
    if (num <= 0 || den <= 0) return '0;
    prd = 128'(num) * 128'(nv);
    q = prd / 128'(den);
    return (q > 128'(ONE_Q)) ? 33'(ONE_Q) : q[32:0];
  endfunction

  function automatic void predict_basis(input bit [31:0] u);
    int n, p, s, lo, hi, j, r, k;
    longint lft[8], rgt[8], den;
    bit [32:0] nb[8];
    bit [32:0] saved, ta, tb;
    bit [33:0] sum;
    basis_word_t w;
    eff_np(int'(ctrl_pts_m), int'(degree_m), n, p);
    if (u >= knots_m[n]) s = n - 1;
    else begin
      lo = p; hi = n; s = (lo + hi) / 2;
      while (hi - lo > 1 && (u < knots_m[s] || u >= knots_m[s + 1])) begin
        if (u < knots_m[s]) hi = s;
        else lo = s;
        s = (lo + hi) / 2;
      end
    end
    nb[0] = 33'(ONE_Q);
    for (j = 1; j <= p; j++) begin
      saved = '0;
      lft[j] = longint'(u) - longint'(knots_m[s + 1 - j]);
      rgt[j] = longint'(knots_m[s + j]) - longint'(u);
      for (r = 0; r < j; r++) begin
        den = rgt[r + 1] + lft[j - r];
        ta = scaled_term(rgt[r + 1], nb[r], den);
        tb = scaled_term(lft[j - r], nb[r], den);
        sum = 34'(saved) + 34'(ta);
        nb[r] = (sum > 34'(ONE_Q)) ? 33'(ONE_Q) : sum[32:0];
        saved = tb;
      end
      nb[j] = saved;
    end
    for (k = 0; k <= p; k++) begin
      w.span = s[5:0];
      w.bidx = k[2:0];
      w.val = nb[k][31:0];
      w.last = (k == p);
      expected_basis.push_back(w);
    end
  endfunction

  function automatic void take_word(input cmd_t c);
    if (c.op == OP_WRITE) begin
      n_writes++;
      if (c.idx < STORE_DEPTH) knots_m[c.idx] = c.kval;
    end else begin
      n_evals++;
      predict_basis(c.u);
    end
  endfunction

  always @(posedge clk) begin : driver
    cmd_t c;
    bit go;
    bit cw;
    go = start;
    cw = 1'b0;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst_n) begin
      go = 1'b0;
    end else begin
      if (start && !busy) begin
        take_word(cur);
        go = 1'b0;
        if (pending.size() > 25 && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 18);
      end
      if (!go) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() > 0) begin
          c = pending[0];
          case (c.kind)
            K_DRAIN: begin
              if (expected_basis.size() == 0 && !busy) begin
                if (settle < SETTLE_CYCLES) settle++;
                else begin
                  settle = 0;
                  void'(pending.pop_front());
                end
              end else settle = 0;
            end
            K_CFG: begin
              cw = 1'b1;
              cfg_index <= c.reg_sel;
              cfg_data <= c.reg_val;
              if (c.reg_sel == REG_CTRL_PTS) ctrl_pts_m = c.reg_val;
              else degree_m = c.reg_val[2:0];
              void'(pending.pop_front());
            end
            default: begin
              go = 1'b1;
              in_operation <= c.op;
              in_knot_index <= c.idx;
              in_knot_value <= c.kval;
              in_param_u <= c.u;
              cur = c;
              void'(pending.pop_front());
            end
          endcase
        end
      end
    end
    start <= go;
    cfg_we <= cw;
  end

  always @(posedge clk) begin : monitor
    basis_word_t w;
    if (rst_n && out_valid) begin
      n_words++;
      if (expected_basis.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: span %0d idx %0d val %h last %0d",
                                   out_span_index, out_basis_index, out_basis_value, out_last);
      end else begin
        w = expected_basis.pop_front();
        if (out_span_index !== w.span || out_basis_index !== w.bidx ||
            out_basis_value !== w.val || out_last !== w.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp span %0d idx %0d val %h last %0d, got %0d %0d %h %0d",
                     w.span, w.bidx, w.val, w.last, out_span_index, out_basis_index,
                     out_basis_value, out_last);
        end
      end
    end
  end

  task automatic push_write(input bit [6:0] idx, input bit [31:0] v);
    cmd_t c;
    c = '{kind: K_ITEM, op: OP_WRITE, idx: idx, kval: v, u: $urandom, reg_sel: 1'b0,
          reg_val: '0};
    pending.push_back(c);
    if (idx < STORE_DEPTH) knots_f[idx] = v;
  endtask

  task automatic push_eval(input bit [31:0] u);
    cmd_t c;
    c = '{kind: K_ITEM, op: OP_EVAL, idx: 7'($urandom), kval: $urandom_range(0, ONE_Q), u: u,
          reg_sel: 1'b0, reg_val: '0};
    pending.push_back(c);
  endtask

  task automatic set_regs(input bit [6:0] rn, input bit [6:0] rp);
    cmd_t c;
    c = '{kind: K_DRAIN, op: 1'b0, idx: '0, kval: '0, u: '0, reg_sel: 1'b0, reg_val: '0};
    pending.push_back(c);
    c.kind = K_CFG;
    c.reg_sel = REG_CTRL_PTS; c.reg_val = rn;
    pending.push_back(c);
    c.reg_sel = REG_DEGREE; c.reg_val = rp;
    pending.push_back(c);
    fill_n = int'(rn); fill_p = int'(rp[2:0]);
    n_phases++;
  endtask

  task automatic load_knots(input bit clamped);
    int n, p, i, cnt;
    bit [31:0] vals[$];
    eff_np(fill_n, fill_p, n, p);
    cnt = n + p + 1;
    for (i = 0; i < cnt; i++) begin
      if (clamped && i <= p) vals.push_back(32'd0);
      else if (clamped && i >= cnt - p - 1) vals.push_back(ONE_Q);
      else if (i > 0 && $urandom_range(0, 3) == 0) vals.push_back(vals[i - 1]);
      else vals.push_back($urandom_range(0, ONE_Q));
    end
    vals.sort();
    for (i = 0; i < cnt; i++) push_write(i[6:0], vals[i]);
  endtask

  task automatic random_words(input int count);
    int n, p, i;
    bit [31:0] a, b;
    eff_np(fill_n, fill_p, n, p);
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: push_write(7'($urandom_range(0, 127)), $urandom_range(0, ONE_Q));
        1: push_eval($urandom_range(0, ONE_Q));
        default: begin
          a = knots_f[p]; b = knots_f[n];
          push_eval((a <= b) ? $urandom_range(a, b) : $urandom_range(b, a));
        end
      endcase
    end
  endtask

  initial begin
    bit [6:0] rn;
    int i;
    // reset config n=4 p=3, clamped knots
    for (i = 0; i < 8; i++) push_write(i[6:0], (i < 4) ? 32'd0 : ONE_Q);
    push_eval(32'd0);
    push_eval(ONE_Q);
    push_eval(32'h4000_0000);
    push_eval(32'd1);
    push_eval(32'h7FFF_FFFF);
    push_write(7'd72, 32'h7FFF_FFFF);
    push_write(7'd127, ONE_Q);
    push_write(7'd2, 32'h6000_0000);
    push_eval(32'h2000_0000);
    push_eval(32'h7000_0000);
    push_write(7'd2, 32'd0);
    // register extremes and clamping
    set_regs(7'd2, 7'd1);
    load_knots(1'b1);
    push_eval(32'd0); push_eval(ONE_Q); push_eval(32'h3000_0000);
    set_regs(7'd64, 7'd7);
    load_knots(1'b0);
    random_words(4);
    set_regs(7'd0, 7'd0);
    load_knots(1'b0);
    push_eval(32'd0); push_eval(ONE_Q);
    set_regs(7'd127, 7'd7);
    random_words(3);
    set_regs(7'd2, 7'd7);
    load_knots(1'b1);
    push_eval(32'h5555_5555); push_eval(ONE_Q);
    // random phases
    for (i = 0; i < 2; i++) begin
      rn = 7'($urandom_range(2, 10));
      set_regs(rn, 7'($urandom_range(0, 7)));
      load_knots(1'($urandom_range(0, 1)));
      random_words(4);
    end
    // pause until all words are out, then the tail runs without idling
    set_regs(7'd6, 7'd2);
    load_knots(1'b1);
    random_words(8);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() != 0 || start || expected_basis.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_basis.size() != 0) errors++;
    $display("covered %0d evaluations, %0d knot writes, %0d basis words over %0d settings",
             n_evals, n_writes, n_words, n_phases);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
